FILE: hw/rtl/zmr_pkg.sv
// shared types and constants for the random opcode unit
`default_nettype none

package zmr_pkg;

  // generator constants
  localparam logic [31:0] LcgMult = 32'h015A_4E35;
  localparam logic [31:0] LcgInc  = 32'd1;

  // field widths
  localparam int OpW   = 16;
  localparam int SeedW = 32;
  localparam int ValW  = 15;
  localparam int CntW  = 10;

  // reseed values below this select the counting mode
  localparam logic [OpW:0] SpecialLimit = 17'd1000;

  // one quotient bit per divider step
  localparam int DivSteps = ValW;
  localparam int StepW    = $clog2(DivSteps);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOADX,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/zmr_moddiv.sv
// iterative restoring modulo unit, one bit per cycle
`default_nettype none

module zmr_moddiv
  import zmr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [ValW-1:0] dividend,
  input  wire logic [ValW-1:0] divisor,
  output logic                 done,
  output logic [ValW-1:0]      remainder
);

  logic [ValW-1:0]  rem;
  logic [ValW-1:0]  dvd;
  logic [ValW-1:0]  dsr;
  logic [StepW-1:0] cnt;
  logic             busy;
  logic [ValW:0]    trial;
  logic [ValW:0]    diff;
  logic             fits;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dvd[ValW-1]};
    diff  = trial - {1'b0, dsr};
    fits  = trial >= {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= StepW'(DivSteps - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[ValW-1:0] : trial[ValW-1:0];
      dvd <= {dvd[ValW-2:0], 1'b0};
    end
  end

  assign remainder = rem;

endmodule

`default_nettype wire

FILE: hw/rtl/zmachine_random_unit.sv
// random opcode unit: lcg or counter source, reseeding and modulo sequencer
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   item     | item_valid/item_ready, operand,      | in
//            | host_seed                            |
//   result   | result_valid/result_ready,           | out
//            | stored_value                         |
//
// a reseed (zero or negative operand) passes from the transfer to the done state,
// then to the output register. a positive operand in lcg mode passes the multiply,
// the pick of the seed bits, the 15 steps of the modulo unit, the take of the
// remainder and the load of the output register; counting mode skips the first two.
// one item is in flight at a time; item_ready is high only while idle.
// a stalled result holds in the output register while the next item is taken.
// reset is synchronous: seed 1, standard mode, counter zero, no result pending.
`default_nettype none

module zmachine_random_unit
  import zmr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_ready,
  input  wire logic signed [OpW-1:0]   operand,
  input  wire logic        [SeedW-1:0] host_seed,
  output logic                         result_valid,
  input  wire logic                    result_ready,
  output logic             [ValW-1:0]  stored_value
);

  state_t state;
  state_t state_next;

  logic [SeedW-1:0] lcg_seed;
  logic [CntW-1:0]  cycle_interval;
  logic [CntW-1:0]  cycle_count;
  logic [CntW-1:0]  count_step;

  logic [ValW-1:0]  range;
  logic [ValW-1:0]  res;

  logic             item_xfer;
  logic             op_zero;
  logic             op_neg;
  logic [OpW:0]     neg_val;
  logic             slot_free;

  logic             div_start;
  logic [ValW-1:0]  div_dividend;
  logic             div_done;
  logic [ValW-1:0]  div_rem;

  // input decode
  always_comb begin
    item_xfer  = item_valid && item_ready;
    op_zero    = operand == '0;
    op_neg     = operand[OpW-1];
    neg_val    = (OpW+1)'(17'h1_0000 - {1'b0, operand});
    slot_free  = !result_valid || result_ready;
    count_step = cycle_count + 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_xfer) begin
          if (op_zero || op_neg)       state_next = ST_DONE;
          else if (cycle_interval != '0) state_next = ST_DIV;
          else                         state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_LOADX;
      ST_LOADX: state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_ready   = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    case (state)
      ST_IDLE: begin
        item_ready   = 1'b1;
        div_start    = item_valid && !op_zero && !op_neg && (cycle_interval != '0);
        div_dividend = {{(ValW-CntW){1'b0}}, cycle_count};
      end
      ST_LOADX: begin
        div_start    = 1'b1;
        div_dividend = lcg_seed[30:16];
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  // generator state and reseeding
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      lcg_seed       <= 32'd1;
      cycle_interval <= '0;
      cycle_count    <= '0;
    end else begin
      state <= state_next;
      if (item_xfer) begin
        if (op_zero) begin
          lcg_seed       <= host_seed;
          cycle_interval <= '0;
        end else if (op_neg && neg_val < SpecialLimit) begin
          cycle_count    <= '0;
          cycle_interval <= neg_val[CntW-1:0];
        end else if (op_neg) begin
          lcg_seed       <= SeedW'(neg_val);
          cycle_interval <= '0;
        end else if (cycle_interval != '0) begin
          cycle_count <= (count_step >= cycle_interval) ? '0 : count_step;
        end
      end
      if (state == ST_MUL) begin
        lcg_seed <= lcg_seed * LcgMult + LcgInc;
      end
    end
  end

  // range and pending result
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      range <= operand[ValW-1:0];
      res   <= '0;
    end else if (div_done) begin
      res <= div_rem + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && slot_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && slot_free) begin
      stored_value <= res;
    end
  end

  // shared modulo unit; the range comes straight from the port in counting mode
  zmr_moddiv u_moddiv (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (state == ST_IDLE ? operand[ValW-1:0] : range),
    .done      (div_done),
    .remainder (div_rem)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/zmr_checker.sv
// port-level checks for the random opcode unit, bound to the top level
`default_nettype none

module zmr_port_checks
  import zmr_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    item_valid,
  input wire logic                    item_ready,
  input wire logic signed [OpW-1:0]   operand,
  input wire logic        [SeedW-1:0] host_seed,
  input wire logic                    result_valid,
  input wire logic                    result_ready,
  input wire logic        [ValW-1:0]  stored_value
);

  // no result is offered straight after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered after reset");

  // one item at a time: no second transfer right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while busy");

  // a reseed with a free output slot offers zero via the done state and the output register
  a_reseed_zero: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (operand[OpW-1] || operand == '0) && !result_valid
      |=> ##1 result_valid && stored_value == '0)
    else $error("reseed did not store zero");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(stored_value))
    else $error("stalled result changed");

  logic unused_seed;
  assign unused_seed = ^host_seed;

endmodule

bind zmachine_random_unit zmr_port_checks u_zmr_port_checks (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .operand      (operand),
  .host_seed    (host_seed),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .stored_value (stored_value)
);

`default_nettype wire

FILE: sim/zmr_checker.sv
// checker for the random opcode unit: predicts each stored value and compares result transfers
`default_nettype none

module zmr_checker
  import zmr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  input  wire logic                    item_ready,
  input  wire logic signed [OpW-1:0]   operand,
  input  wire logic        [SeedW-1:0] host_seed,
  input  wire logic                    result_valid,
  input  wire logic                    result_ready,
  input  wire logic        [ValW-1:0]  stored_value,
  output int                           fail_count,
  output int                           pending,
  output int                           checked
);

  localparam logic [31:0] GenMult    = 32'h015A_4E35;
  localparam logic [31:0] GenInc     = 32'd1;
  localparam int          CountLimit = 1000;

  // predicted unit state
  logic [SeedW-1:0] gen_seed;
  logic [CntW-1:0]  count_period;
  logic [CntW-1:0]  count_pos;

  logic [ValW-1:0] stored_fifo[$];

  // one opcode: reseed and store zero, or draw a value in 1..range
  function automatic logic [ValW-1:0] next_stored_value(input logic signed [OpW-1:0] op,
                                                        input logic [SeedW-1:0] host);
    int              v;
    logic [ValW-1:0] x;
    logic [ValW-1:0] range;
    if (op <= 0) begin
      v = -int'(op);
      if (v == 0) begin
        gen_seed     = host;
        count_period = '0;
      end else if (v < CountLimit) begin
        count_pos    = '0;
        count_period = v[CntW-1:0];
      end else begin
        gen_seed     = v;
        count_period = '0;
      end
      return '0;
    end
    range = op[ValW-1:0];
    if (count_period != '0) begin
      // counting mode: use, then step and wrap at the period
      x         = ValW'(count_pos);
      count_pos = count_pos + 1'b1;
      if (count_pos >= count_period) count_pos = '0;
    end else begin
      gen_seed = gen_seed * GenMult + GenInc;
      x        = gen_seed[30:16];
    end
    return x % range + 1'b1;
  endfunction

  // watch both channels on the rising edge
  always @(posedge clk) begin
    logic [ValW-1:0] want;
    if (rst) begin
      gen_seed     = 32'd1;
      count_period = '0;
      count_pos    = '0;
      stored_fifo.delete();
      fail_count   = 0;
      checked      = 0;
    end else begin
      // a result transfer belongs to the oldest item in flight
      if (result_valid && result_ready) begin
        if (stored_fifo.size() == 0) begin
          $error("stored_value: unexpected result %0d", stored_value);
          fail_count++;
        end else begin
          want = stored_fifo.pop_front();
          checked++;
          if (stored_value !== want) begin
            $error("stored_value: expected %0d, actual %0d", want, stored_value);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready)
        stored_fifo.push_back(next_stored_value(operand, host_seed));
    end
    pending = stored_fifo.size();
  end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// testbench top for the random opcode unit: stimulus, handshake pacing and verdict
`default_nettype none

module tb;
  import zmr_pkg::*;

  localparam int RandomItems = 2000;
  localparam int HoldCycles  = 300;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    item_valid;
  logic                    item_ready;
  logic signed [OpW-1:0]   operand;
  logic        [SeedW-1:0] host_seed;
  logic                    result_valid;
  logic                    result_ready;
  logic        [ValW-1:0]  stored_value;

  int fail_count;
  int pending;
  int checked;

  // pacing controls shared by sender and receiver
  bit calm;
  bit hold_req;

  int n_items;
  int n_ranges;
  int n_host_reseeds;
  int n_count_reseeds;
  int n_seed_reseeds;

  zmachine_random_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operand      (operand),
    .host_seed    (host_seed),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stored_value (stored_value)
  );

  zmr_checker chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operand      (operand),
    .host_seed    (host_seed),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stored_value (stored_value),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offer one opcode, maybe after a short gap, and wait for its transfer
  task automatic send_op(input logic signed [OpW-1:0] op, input logic [SeedW-1:0] host);
    int gap;
    if (!calm && $urandom_range(99) < 19) begin
      gap        = $urandom_range(1, 4);
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    operand    = op;
    host_seed  = host;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
    n_items++;
    if (op > 0) n_ranges++;
    else if (op == 0) n_host_reseeds++;
    else if (-int'(op) < 1000) n_count_reseeds++;
    else n_seed_reseeds++;
  endtask

  // result side: random stalls, calm stretch and one long hold-off
  initial begin
    int held;
    bit hold_done;
    held         = 0;
    hold_done    = 1'b0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        held      = HoldCycles;
      end
      if (held > 0) begin
        result_ready = 1'b0;
        held--;
      end else if (calm) begin
        result_ready = 1'b1;
      end else begin
        result_ready = ($urandom_range(99) >= 19);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int pick;
    int opv;
    rst        = 1'b1;
    item_valid = 1'b0;
    operand    = '0;
    host_seed  = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed: range extremes, every reseed kind, counter wrap
    send_op(16'sd1, $urandom);
    send_op(16'sd32767, $urandom);
    send_op(16'sd2, $urandom);
    send_op(16'sd0, 32'hFFFF_FFFF);
    send_op(16'sd32767, $urandom);
    send_op(16'sd0, 32'h0000_0000);
    send_op(16'sd32767, $urandom);
    send_op(-16'sd32768, $urandom);
    send_op(16'sd100, $urandom);
    send_op(-16'sd1000, $urandom);
    send_op(16'sd12345, $urandom);
    send_op(-16'sd999, $urandom);
    send_op(16'sd32767, $urandom);
    send_op(-16'sd1, $urandom);
    send_op(16'sd7, $urandom);
    send_op(16'sd7, $urandom);
    send_op(-16'sd3, $urandom);
    repeat (4) send_op(16'sd5, $urandom);
    send_op(-16'sd32767, $urandom);
    send_op(16'sd16384, $urandom);
    send_op(16'sd0, $urandom);
    send_op(16'sd1, $urandom);

    // random opcodes, mostly draws so both modes run long
    for (int i = 0; i < RandomItems; i++) begin
      calm = (i >= 400 && i < 700);
      if (i == 1000) hold_req = 1'b1;
      if (i == 1500) begin
        item_valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 65) begin
        if ($urandom_range(1) == 1) opv = $urandom_range(1, 64);
        else opv = $urandom_range(1, 32767);
      end else if (pick < 75) begin
        opv = 0;
      end else if (pick < 88) begin
        if ($urandom_range(1) == 1) opv = -int'($urandom_range(1, 20));
        else opv = -int'($urandom_range(1, 999));
      end else begin
        opv = -int'($urandom_range(1000, 32768));
      end
      send_op(opv[OpW-1:0], $urandom);
    end
    calm       = 1'b0;
    item_valid = 1'b0;

    wait (pending == 0);
    repeat (25) @(posedge clk);

    $display("summary: %0d opcodes sent, %0d stored values checked, %0d draws",
             n_items, checked, n_ranges);
    $display("summary: reseeds from host %0d, counting mode %0d, direct seed %0d",
             n_host_reseeds, n_count_reseeds, n_seed_reseeds);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20 * 400000);
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/zmr_pkg.sv
hw/rtl/zmr_moddiv.sv
hw/rtl/zmachine_random_unit.sv
hw/rtl/zmr_checker.sv
sim/zmr_checker.sv
sim/tb.sv
